FILE: rtl/spt_pkg.sv
// Shared types, constants and prime tables for the small prime table classifier.
// Used by spt_ctrl, spt_dp, small_prime_table_classifier_top and the testbench; no dependencies.
`default_nettype none

package spt_pkg;

  localparam int PRIME_COUNT    = 100;
  localparam int TABLE_SIZE_DEF = 100;
  localparam int VAL_W          = 31;
  localparam int CLS_W          = 2;
  localparam int PRIME_W        = 10;
  localparam int IDX_W          = $clog2(PRIME_COUNT);
  localparam int PROD_W         = 32;

  localparam logic [CLS_W-1:0] CLS_LISTED   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MULTIPLE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_NEITHER  = 2'd2;

  typedef logic [PRIME_W-1:0] prime_rom_t [PRIME_COUNT];
  typedef logic [PROD_W-1:0]  word_rom_t  [PRIME_COUNT];

  localparam prime_rom_t PRIME_ROM = '{
    10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,  10'd23,  10'd29,
    10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,  10'd59,  10'd61,  10'd67,  10'd71,
    10'd73,  10'd79,  10'd83,  10'd89,  10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113,
    10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
    10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223, 10'd227, 10'd229,
    10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269, 10'd271, 10'd277, 10'd281,
    10'd283, 10'd293, 10'd307, 10'd311, 10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349,
    10'd353, 10'd359, 10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
    10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463,
    10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541
  };

  // Divisibility by multiplication: v*inv mod 2^32 <= lim exactly when p divides v.
  // Odd p uses its inverse mod 2^32; p = 2 uses inv = 2^31, lim = 0 (tests bit 0).
  function automatic word_rom_t build_inv();
    word_rom_t r;
    logic [PROD_W-1:0] p;
    logic [PROD_W-1:0] x;
    for (int k = 0; k < PRIME_COUNT; k++) begin
      p = PROD_W'(PRIME_ROM[k]);
      if (p == 32'd2) begin
        x = 32'h8000_0000;
      end else begin
        x = p;
        for (int i = 0; i < 5; i++) begin
          x = x * (32'd2 - p * x);
        end
      end
      r[k] = x;
    end
    return r;
  endfunction

  // lim = floor((2^32-1)/p) for odd p, by restoring long division of the all-ones word; p = 2 gets 0
  function automatic word_rom_t build_lim();
    word_rom_t r;
    logic [PROD_W-1:0] p;
    logic [PROD_W:0]   rem;
    logic [PROD_W-1:0] q;
    for (int k = 0; k < PRIME_COUNT; k++) begin
      p = PROD_W'(PRIME_ROM[k]);
      if (p == 32'd2) begin
        r[k] = '0;
      end else begin
        rem = '0;
        q   = '0;
        for (int i = PROD_W - 1; i >= 0; i--) begin
          rem = {rem[PROD_W-1:0], 1'b1};
          if (rem >= {1'b0, p}) begin
            rem  = rem - {1'b0, p};
            q[i] = 1'b1;
          end
        end
        r[k] = q;
      end
    end
    return r;
  endfunction

  localparam word_rom_t INV_ROM = build_inv();
  localparam word_rom_t LIM_ROM = build_lim();

  typedef struct packed {
    logic load;
    logic issue;
    logic capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/spt_ctrl.sv
// Controller state machine for the small prime table classifier.
// Depends on spt_pkg; drives spt_dp through cmd_t and reads sts_t.
`default_nettype none

module spt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  spt_pkg::sts_t      sts,
  output spt_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.done) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_FIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/spt_dp.sv
// Datapath: table index, one-prime-per-cycle multiply/compare pipe, result register.
// Depends on spt_pkg; steered by spt_ctrl through cmd_t.
`default_nettype none

module spt_dp #(
  parameter int TABLE_SIZE = spt_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [spt_pkg::VAL_W-1:0]    in_value,
  input  spt_pkg::cmd_t                     cmd,
  output spt_pkg::sts_t                     sts,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic [spt_pkg::CLS_W-1:0]         out_class_code
);

  // walk length saturated to the table; an empty walk issues one entry and ignores it
  localparam int   WALK_LEN = (TABLE_SIZE < 1) ? 0 :
                              (TABLE_SIZE > spt_pkg::PRIME_COUNT) ? spt_pkg::PRIME_COUNT :
                              TABLE_SIZE;
  localparam int   LAST_IDX = (WALK_LEN < 1) ? 0 : WALK_LEN - 1;
  localparam logic WALK_ON  = (WALK_LEN > 0);

  logic [spt_pkg::VAL_W-1:0]   value_r;
  logic [spt_pkg::IDX_W-1:0]   idx_r;
  logic [spt_pkg::PRIME_W-1:0] prime;
  logic                        idx_last;

  logic [spt_pkg::PROD_W-1:0]  prod_r, lim_r;
  logic                        eq_r, ge_r, a_vld_r, a_last_r;

  logic                        listed, mult;
  logic [spt_pkg::CLS_W-1:0]   cls_nxt, cls_r;
  logic                        out_valid_r;
  logic [spt_pkg::CLS_W-1:0]   out_cls_r;

  assign prime    = spt_pkg::PRIME_ROM[idx_r];
  assign idx_last = (idx_r == spt_pkg::IDX_W'(LAST_IDX));

  // Index and issue stage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      idx_r   <= '0;
    end else if (cmd.issue && !idx_last) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.issue) begin
      prod_r   <= spt_pkg::PROD_W'({1'b0, value_r} * spt_pkg::INV_ROM[idx_r]);
      lim_r    <= spt_pkg::LIM_ROM[idx_r];
      eq_r     <= (value_r == spt_pkg::VAL_W'(prime));
      ge_r     <= (value_r >= spt_pkg::VAL_W'(prime));
      a_last_r <= idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= cmd.issue;
    end
  end

  // Decision stage
  assign listed = WALK_ON && eq_r;
  assign mult   = WALK_ON && ge_r && (prod_r <= lim_r);

  always_comb begin
    if (listed) begin
      cls_nxt = spt_pkg::CLS_LISTED;
    end else if (mult) begin
      cls_nxt = spt_pkg::CLS_MULTIPLE;
    end else begin
      cls_nxt = spt_pkg::CLS_NEITHER;
    end
  end

  assign sts = '{done:     a_vld_r && (listed || mult || a_last_r),
                 out_free: !out_valid_r || !out_stall};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cls_r <= cls_nxt;
    end
    if (cmd.out_load) begin
      out_cls_r <= cls_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_class_code = out_cls_r;

endmodule

`default_nettype wire

FILE: rtl/small_prime_table_classifier_top.sv
// Top level of the small prime table classifier: spt_ctrl plus spt_dp.
// Depends on spt_pkg, spt_ctrl and spt_dp.
//
//   channel  ports                          beat
//   in       in_valid, in_stall, in_value   one 31-bit value to classify
//   out      out_valid, out_stall,          one 2-bit class per value
//            out_class_code
//
// One table prime is tested per cycle by a 32-bit multiply and compare in spt_dp.
// The walk ends at the first table entry that hits, or after the last entry with no hit.
// One value is in flight at a time.
// Synchronous active-low reset clears the state machine and the valid flags.
// A stalled result holds; the next value is taken while it waits.
`default_nettype none

module small_prime_table_classifier_top #(
  parameter int TABLE_SIZE = spt_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [spt_pkg::VAL_W-1:0]    in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [spt_pkg::CLS_W-1:0]         out_class_code
);

  spt_pkg::cmd_t cmd;
  spt_pkg::sts_t sts;

  spt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spt_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_class_code (out_class_code)
  );

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

  a_class_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_class_code == spt_pkg::CLS_LISTED ||
                   out_class_code == spt_pkg::CLS_MULTIPLE ||
                   out_class_code == spt_pkg::CLS_NEITHER))
    else $error("illegal class code");

  a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  a_one_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.issue, cmd.capture, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

FILE: tb/prime_class_checker.sv
// Checker for small_prime_table_classifier_top: watches both channels, predicts each class
// by its own trial division over the first primes, and compares in order.
// Depends on spt_pkg for widths and class codes.
module prime_class_checker #(
  parameter int TABLE_SIZE = spt_pkg::TABLE_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [spt_pkg::VAL_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [spt_pkg::CLS_W-1:0] out_class_code,
  output int                        mismatch_count,
  output int                        classes_pending
);
  import spt_pkg::*;

  localparam int WALK_LEN = (TABLE_SIZE < 0) ? 0 :
                            (TABLE_SIZE > PRIME_COUNT) ? PRIME_COUNT : TABLE_SIZE;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CLS_W-1:0] cls;
  } class_expect_t;

  int            prime_list [PRIME_COUNT];
  class_expect_t class_q [$];

  initial begin
    int found;
    int cand;
    bit is_p;
    found = 0;
    cand = 2;
    mismatch_count = 0;
    classes_pending = 0;
    while (found < PRIME_COUNT) begin
      is_p = 1'b1;
      for (int d = 2; d * d <= cand; d++) begin
        if (cand % d == 0) is_p = 1'b0;
      end
      if (is_p) begin
        prime_list[found] = cand;
        found++;
      end
      cand++;
    end
  end

  function automatic logic [CLS_W-1:0] trial_class(input logic [VAL_W-1:0] v);
    logic [31:0] p;
    for (int k = 0; k < WALK_LEN; k++) begin
      p = prime_list[k];
      if ({1'b0, v} == p) return CLS_LISTED;
      if ({1'b0, v} >= p && {1'b0, v} % p == 0) return CLS_MULTIPLE;
    end
    return CLS_NEITHER;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    class_expect_t head;
    if (rst_n) begin
      // result side first: a beat leaving now belongs to an older value
      if (out_valid && !out_stall) begin
        if (class_q.size() == 0) begin
          report_mismatch($sformatf("class %0d with no value waiting", out_class_code));
        end else begin
          head = class_q.pop_front();
          if (out_class_code !== head.cls) begin
            report_mismatch($sformatf("value %0d: class %0d, want %0d",
                                      head.value, out_class_code, head.cls));
          end
        end
      end
      if (in_valid && !in_stall) begin
        class_q.push_back('{value: in_value, cls: trial_class(in_value)});
      end
      classes_pending = class_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the testbench for small_prime_table_classifier_top: clock, reset, value stimulus,
// random idling on both channels and the verdict. Depends on spt_pkg, the block and
// prime_class_checker.
module testbench;
  import spt_pkg::*;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int PHASE_BEATS  = 550;
  localparam int CORNER_COUNT = 22;
  localparam int STIM_PRIMES  = 300;

  localparam logic [VAL_W-1:0] CORNER_VALS [CORNER_COUNT] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd9, 31'd25, 31'd529, 31'd541, 31'd539,
    31'd542, 31'd543, 31'd547, 31'd292681, 31'd299209, 31'd282943, 31'd2147483647,
    31'd2147483646, 31'd1073741824, 31'd1431655765, 31'd715827882, 31'd1022117
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic             out_stall;
  logic [CLS_W-1:0] out_class_code;

  int mismatch_count;
  int classes_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int stim_primes [STIM_PRIMES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  small_prime_table_classifier_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_class_code (out_class_code)
  );

  prime_class_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_class_code  (out_class_code),
    .mismatch_count  (mismatch_count),
    .classes_pending (classes_pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // valid is only lowered when a gap follows, so it never drops and rises in one step
  task automatic send_value(input logic [VAL_W-1:0] v);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_value <= VAL_W'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [63:0] prod;
    int          sel;
    int          p;
    sel = $urandom_range(99);
    if (sel < 25) begin
      return VAL_W'($urandom);
    end else if (sel < 38) begin
      return VAL_W'($urandom) | VAL_W'(1);
    end else if (sel < 52) begin
      return VAL_W'(stim_primes[$urandom_range(PRIME_COUNT - 1)]);
    end else if (sel < 67) begin
      p = stim_primes[$urandom_range(PRIME_COUNT - 1)];
      return VAL_W'(p * $urandom_range(1, 32'h7FFF_FFFF / p));
    end else if (sel < 85) begin
      // products of primes past the table: no entry divides them
      prod = 64'(stim_primes[$urandom_range(STIM_PRIMES - 1, PRIME_COUNT)]);
      repeat ($urandom_range(2)) begin
        p = stim_primes[$urandom_range(STIM_PRIMES - 1, PRIME_COUNT)];
        if (prod * p <= 64'h7FFF_FFFF) prod = prod * p;
      end
      return VAL_W'(prod);
    end else if (sel < 95) begin
      return VAL_W'($urandom_range(1200));
    end else begin
      return VAL_W'(32'h7FFF_FFFF - $urandom_range(4095));
    end
  endfunction

  initial begin
    int  found;
    int  cand;
    bit  is_p;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    found = 0;
    cand = 2;
    while (found < STIM_PRIMES) begin
      is_p = 1'b1;
      for (int d = 2; d * d <= cand; d++) begin
        if (cand % d == 0) is_p = 1'b0;
      end
      if (is_p) begin
        stim_primes[found] = cand;
        found++;
      end
      cand++;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        foreach (CORNER_VALS[i]) send_value(CORNER_VALS[i]);
      end
      repeat (PHASE_BEATS) send_value(pick_value());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (classes_pending != 0) @(posedge clk);
    repeat (PRIME_COUNT + 8) @(posedge clk);
    if (mismatch_count == 0 && classes_pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/spt_pkg.sv
rtl/spt_ctrl.sv
rtl/spt_dp.sv
rtl/small_prime_table_classifier_top.sv
tb/prime_class_checker.sv
tb/testbench.sv
